// ===== rtl/core/tfap_pkg.sv =====
// shared types and codes for the team filtered box pair scan
package tfap_pkg;

   localparam int ID_W   = 16;
   localparam int TEAM_W = 8;
   localparam int SIZE_W = 15;
   localparam int POS_W  = 16;
   localparam int BOX_W  = 17;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_POS  = 2'd1,
      FUNC_SCAN = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_HIT,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic [TEAM_W-1:0]        team;
      logic [SIZE_W-1:0]        size_w;
      logic [SIZE_W-1:0]        size_h;
      logic signed [BOX_W-1:0]  x_low;
      logic signed [BOX_W-1:0]  y_low;
      logic signed [BOX_W-1:0]  x_high;
      logic signed [BOX_W-1:0]  y_high;
   } entry_type;

   typedef struct packed {
      logic                     en;
      logic [ID_W-1:0]          id;
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
   } pos_cmd_type;

endpackage

// ===== rtl/core/tfap_if.sv =====
// request and response channel interfaces
interface tfap_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [15:0]          entity_id;
   logic [14:0]          box_width;
   logic [14:0]          box_height;
   logic [7:0]           team_tag;
   logic signed [15:0]   pos_x;
   logic signed [15:0]   pos_y;

   modport source (output valid, func, entity_id, box_width, box_height, team_tag,
                   pos_x, pos_y, input ready);
   modport sink (input valid, func, entity_id, box_width, box_height, team_tag,
                 pos_x, pos_y, output ready);
endinterface

interface tfap_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] first_entity;
   logic [15:0] second_entity;
   logic        pair_valid;
   logic        last_pair;
   logic        table_full;

   modport source (output valid, first_entity, second_entity, pair_valid, last_pair,
                   table_full, input ready);
   modport sink (input valid, first_entity, second_entity, pair_valid, last_pair,
                 table_full, output ready);
endinterface

// ===== rtl/core/tfap_cell.sv =====
// one table entry with its position update and overlap test against the probe
module tfap_cell
   import tfap_pkg::*;
(
   input  logic        clock,
   input  logic        add_en,
   input  entry_type   add_entry,
   input  pos_cmd_type pos_cmd,
   input  entry_type   probe,
   output entry_type   ent,
   output logic        hit
);

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (add_en) begin
         ent_in = add_entry;
      end else if (pos_cmd.en && (pos_cmd.id == ent_ff.id)) begin
         ent_in.x_low  = BOX_W'(pos_cmd.x);
         ent_in.y_low  = BOX_W'(pos_cmd.y);
         ent_in.x_high = BOX_W'(pos_cmd.x) + $signed({2'b00, ent_ff.size_w});
         ent_in.y_high = BOX_W'(pos_cmd.y) + $signed({2'b00, ent_ff.size_h});
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

   // strict overlap on both axes, other team only
   assign hit = (probe.team != ent_ff.team) &&
                (probe.x_low < ent_ff.x_high) && (probe.x_high > ent_ff.x_low) &&
                (probe.y_low < ent_ff.y_high) && (probe.y_high > ent_ff.y_low);

endmodule

// ===== rtl/core/team_filtered_aabb_pair_scan.sv =====
// Team filtered box pair scan: a row of MAX_ENTITIES entry cells. Add, position
// update and unused codes give one beat. A scan walks the table one probe
// entry at a time: the load and hit states load the probe and latch the
// overlap hits of all later entries in parallel, then the drain state sends
// the colliding pairs one at a time, waiting while the response register is
// full. One pair is held back so the final beat can carry last_pair; a scan
// with no pair gives a single beat with pair_valid low. The next request
// is taken once the response register is empty and the block is idle.
module team_filtered_aabb_pair_scan
   import tfap_pkg::*;
#(
   parameter int MAX_ENTITIES = 8
)(
   input  logic        clock,
   input  logic        reset,
   tfap_req_if.sink    req_chan,
   tfap_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(MAX_ENTITIES);
   localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   entry_type        probe_ff;
   logic [MAX_ENTITIES-1:0] hit_ff, hit_in;
   logic             pend_ff, pend_in;
   logic [ID_W-1:0]  pend_first_ff, pend_second_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_first_ff, rsp_second_ff;
   logic             rsp_pair_ff, rsp_last_ff, rsp_full_ff;

   entry_type               ents [MAX_ENTITIES];
   logic [MAX_ENTITIES-1:0] hits;
   logic [MAX_ENTITIES-1:0] add_sel;
   entry_type               add_entry;
   pos_cmd_type             pos_cmd;

   logic req_fire, rsp_free, last_probe, hit_any;
   logic [IDX_W-1:0] hit_idx;
   logic [MAX_ENTITIES-1:0] hit_mask;
   func_type func;

   // control strobes from the output block
   logic do_req, do_scan_start, do_probe, do_hit, do_pair, do_next, do_finish;

   assign func     = func_type'(req_chan.func);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign last_probe = (CNT_W'(idx_ff) + CNT_W'(2)) >= count_ff;
   assign hit_any  = |hit_ff;

   always_comb begin
      hit_idx = '0;
      for (int j = MAX_ENTITIES - 1; j >= 0; j--) begin
         if (hit_ff[j]) begin
            hit_idx = IDX_W'(j);
         end
      end
   end

   // entries after the probe that are in use
   always_comb begin
      for (int j = 0; j < MAX_ENTITIES; j++) begin
         hit_mask[j] = (IDX_W'(j) > idx_ff) && (CNT_W'(j) < count_ff);
      end
   end

   assign add_entry.id     = req_chan.entity_id;
   assign add_entry.team   = req_chan.team_tag;
   assign add_entry.size_w = req_chan.box_width;
   assign add_entry.size_h = req_chan.box_height;
   assign add_entry.x_low  = '0;
   assign add_entry.y_low  = '0;
   assign add_entry.x_high = '0;
   assign add_entry.y_high = '0;

   assign pos_cmd.en = req_fire && (func == FUNC_POS);
   assign pos_cmd.id = req_chan.entity_id;
   assign pos_cmd.x  = req_chan.pos_x;
   assign pos_cmd.y  = req_chan.pos_y;

   always_comb begin
      for (int j = 0; j < MAX_ENTITIES; j++) begin
         add_sel[j] = req_fire && (func == FUNC_ADD) && (CNT_W'(j) == count_ff);
      end
   end

   for (genvar g = 0; g < MAX_ENTITIES; g++) begin : g_cell
      tfap_cell u_cell (
         .clock     (clock),
         .add_en    (add_sel[g]),
         .add_entry (add_entry),
         .pos_cmd   (pos_cmd),
         .probe     (probe_ff),
         .ent       (ents[g]),
         .hit       (hits[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (func == FUNC_SCAN) && (count_ff >= CNT_W'(2))) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_HIT;
         ST_HIT:   state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (!hit_any) begin
               state_in = last_probe ? ST_FINISH : ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      do_req        = 1'b0;
      do_scan_start = 1'b0;
      do_probe      = 1'b0;
      do_hit        = 1'b0;
      do_pair       = 1'b0;
      do_next       = 1'b0;
      do_finish     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            do_req        = req_fire;
            do_scan_start = req_fire && (func == FUNC_SCAN) && (count_ff >= CNT_W'(2));
         end
         ST_LOAD:  do_probe = 1'b1;
         ST_HIT:   do_hit   = 1'b1;
         ST_DRAIN: begin
            do_pair = hit_any && (!pend_ff || rsp_free);
            do_next = !hit_any && !last_probe;
         end
         ST_FINISH: do_finish = rsp_free;
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      pend_in  = pend_ff;
      if (do_req && (func == FUNC_ADD) && (count_ff < CNT_W'(MAX_ENTITIES))) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (do_scan_start) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end
      if (do_hit) begin
         hit_in = hits & hit_mask;
      end
      if (do_pair) begin
         hit_in[hit_idx] = 1'b0;
         pend_in = 1'b1;
      end
      if (do_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (do_finish) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (do_req && !do_scan_start) begin
         rsp_valid_in = 1'b1;
      end
      if ((do_pair && pend_ff) || do_finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         hit_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_probe) begin
         probe_ff <= ents[idx_ff];
      end
      if (do_pair) begin
         pend_first_ff  <= probe_ff.id;
         pend_second_ff <= ents[hit_idx].id;
      end
      if (do_req && !do_scan_start) begin
         rsp_first_ff  <= '0;
         rsp_second_ff <= '0;
         rsp_pair_ff   <= 1'b0;
         rsp_last_ff   <= 1'b1;
         rsp_full_ff   <= (func == FUNC_ADD) && (count_ff >= CNT_W'(MAX_ENTITIES));
      end else if (do_pair && pend_ff) begin
         rsp_first_ff  <= pend_first_ff;
         rsp_second_ff <= pend_second_ff;
         rsp_pair_ff   <= 1'b1;
         rsp_last_ff   <= 1'b0;
         rsp_full_ff   <= 1'b0;
      end else if (do_finish) begin
         rsp_first_ff  <= pend_ff ? pend_first_ff : '0;
         rsp_second_ff <= pend_ff ? pend_second_ff : '0;
         rsp_pair_ff   <= pend_ff;
         rsp_last_ff   <= 1'b1;
         rsp_full_ff   <= 1'b0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.first_entity  = rsp_first_ff;
   assign rsp_chan.second_entity = rsp_second_ff;
   assign rsp_chan.pair_valid    = rsp_pair_ff;
   assign rsp_chan.last_pair     = rsp_last_ff;
   assign rsp_chan.table_full    = rsp_full_ff;

endmodule

// ===== rtl/core/tfap_checker.sv =====
// port level checks for the pair scan, bound to the top level
module tfap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_first,
   input logic        rsp_pair,
   input logic        rsp_last,
   input logic        rsp_full
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first))
      else $error("response beat dropped or changed while stalled");

   a_req_excl: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a response beat waits");

   a_no_pair_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pair |-> rsp_last)
      else $error("beat without a pair is not the last");

   a_pair_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair |-> !rsp_full)
      else $error("pair beat flagged table full");

endmodule

bind team_filtered_aabb_pair_scan tfap_checker u_tfap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_first (rsp_chan.first_entity),
   .rsp_pair  (rsp_chan.pair_valid),
   .rsp_last  (rsp_chan.last_pair),
   .rsp_full  (rsp_chan.table_full)
);

// ===== dv/tfap_tb_if.sv =====
`timescale 1ns / 1ps
// response beat type shared by the box pair scan testbench
package tfap_tb_pkg;
   typedef struct packed {
      logic [15:0] first_entity;
      logic [15:0] second_entity;
      logic        pair_valid;
      logic        last_pair;
      logic        table_full;
   } pair_beat_type;
endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench for the team filtered box pair scan: queue driven requests, predicted beats
module testbench;
   import tfap_pkg::*;
   import tfap_tb_pkg::*;

   localparam int N_ENT = 8;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [1:0]         func;
      logic [15:0]        entity_id;
      logic [14:0]        box_width;
      logic [14:0]        box_height;
      logic [7:0]         team_tag;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } scan_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfap_req_if req_chan();
   tfap_rsp_if rsp_chan();

   team_filtered_aabb_pair_scan #(.MAX_ENTITIES(N_ENT)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   scan_req_type  pending_reqs[$];
   pair_beat_type expected_beats[$];
   int            mismatch_count = 0;
   int            fail_count = 0;
   int            stall_cycles = 0;
   int            accepted = 0;
   bit            calm = 1'b0;
   bit            req_taken = 1'b0;

   // table shadow
   int                 tbl_count;
   logic [15:0]        tbl_id[N_ENT];
   logic [7:0]         tbl_team[N_ENT];
   logic [14:0]        tbl_w[N_ENT];
   logic [14:0]        tbl_h[N_ENT];
   logic signed [16:0] tbl_xl[N_ENT], tbl_yl[N_ENT], tbl_xh[N_ENT], tbl_yh[N_ENT];

   function automatic void queue_req(scan_req_type q);
      pending_reqs = {pending_reqs, q};
   endfunction

   function automatic void expect_beat(pair_beat_type b);
      expected_beats = {expected_beats, b};
   endfunction

   function automatic pair_beat_type make_beat(logic [15:0] a, logic [15:0] b,
                                               logic v, logic l, logic f);
      pair_beat_type r;
      r.first_entity = a; r.second_entity = b;
      r.pair_valid = v; r.last_pair = l; r.table_full = f;
      return r;
   endfunction

   task automatic predict_pairs(scan_req_type q);
      int hits;
      case (q.func)
         FUNC_ADD: begin
            if (tbl_count >= N_ENT) begin
               expect_beat(make_beat(0, 0, 0, 1, 1));
            end else begin
               tbl_id[tbl_count] = q.entity_id;
               tbl_team[tbl_count] = q.team_tag;
               tbl_w[tbl_count] = q.box_width;
               tbl_h[tbl_count] = q.box_height;
               tbl_xl[tbl_count] = 0; tbl_yl[tbl_count] = 0;
               tbl_xh[tbl_count] = 0; tbl_yh[tbl_count] = 0;
               tbl_count++;
               expect_beat(make_beat(0, 0, 0, 1, 0));
            end
         end
         FUNC_POS: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_id[i] == q.entity_id) begin
                  tbl_xl[i] = 17'(q.pos_x);
                  tbl_yl[i] = 17'(q.pos_y);
                  tbl_xh[i] = 17'(q.pos_x) + $signed({2'b00, tbl_w[i]});
                  tbl_yh[i] = 17'(q.pos_y) + $signed({2'b00, tbl_h[i]});
               end
            end
            expect_beat(make_beat(0, 0, 0, 1, 0));
         end
         FUNC_SCAN: begin
            hits = 0;
            for (int i = 0; i + 1 < tbl_count; i++)
               for (int k = i + 1; k < tbl_count; k++)
                  if (tbl_team[i] != tbl_team[k] && tbl_xl[i] < tbl_xh[k] &&
                      tbl_xh[i] > tbl_xl[k] && tbl_yl[i] < tbl_yh[k] &&
                      tbl_yh[i] > tbl_yl[k]) begin
                     expect_beat(make_beat(tbl_id[i], tbl_id[k], 1, 0, 0));
                     hits++;
                  end
            if (hits == 0) expect_beat(make_beat(0, 0, 0, 1, 0));
            else expected_beats[$].last_pair = 1'b1;
         end
         default: expect_beat(make_beat(0, 0, 0, 1, 0));
      endcase
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0; req_chan.func <= '0; req_chan.entity_id <= '0;
         req_chan.box_width <= '0; req_chan.box_height <= '0; req_chan.team_tag <= '0;
         req_chan.pos_x <= '0; req_chan.pos_y <= '0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!req_chan.valid || req_taken) begin
            // previous beat taken at the last rising edge (or none pending)
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
               scan_req_type q;
               q = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.func <= q.func; req_chan.entity_id <= q.entity_id;
               req_chan.box_width <= q.box_width; req_chan.box_height <= q.box_height;
               req_chan.team_tag <= q.team_tag;
               req_chan.pos_x <= q.pos_x; req_chan.pos_y <= q.pos_y;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            scan_req_type q;
            q.func = req_chan.func; q.entity_id = req_chan.entity_id;
            q.box_width = req_chan.box_width; q.box_height = req_chan.box_height;
            q.team_tag = req_chan.team_tag; q.pos_x = req_chan.pos_x;
            q.pos_y = req_chan.pos_y;
            predict_pairs(q);
            accepted++;
         end
         // stretch with no idling on either side
         calm <= (accepted >= 200) && (accepted < 280);
         if (rsp_chan.valid && rsp_chan.ready) begin
            pair_beat_type got;
            got = make_beat(rsp_chan.first_entity, rsp_chan.second_entity,
                            rsp_chan.pair_valid, rsp_chan.last_pair, rsp_chan.table_full);
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (mismatch_count++ < 10) $display("unexpected beat %h", got);
            end else begin
               pair_beat_type exp_b;
               exp_b = expected_beats.pop_front();
               if (got !== exp_b) begin
                  fail_count++;
                  if (mismatch_count++ < 10)
                     $display("mismatch: expected %h actual %h", exp_b, got);
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic scan_req_type mk(logic [1:0] f, logic [15:0] id, logic [14:0] w,
                                       logic [14:0] h, logic [7:0] t,
                                       logic [15:0] x, logic [15:0] y);
      scan_req_type q;
      q.func = f; q.entity_id = id; q.box_width = w; q.box_height = h;
      q.team_tag = t; q.pos_x = x; q.pos_y = y;
      return q;
   endfunction

   function automatic logic [15:0] pick_pos();
      case ($urandom_range(3))
         0: return 16'($urandom);
         default: return 16'($urandom_range(200)) - 16'd100;
      endcase
   endfunction

   function automatic logic [14:0] pick_size();
      case ($urandom_range(5))
         0: return 15'($urandom);
         1: return 15'h7fff;
         default: return 15'($urandom_range(120));
      endcase
   endfunction

   initial begin
      int issued;
      int n_ids;
      logic [15:0] ids[N_ENT];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty scan, one entry, extremes, full table, unused code
      queue_req(mk(FUNC_SCAN, 0, 0, 0, 0, 0, 0));
      queue_req(mk(FUNC_ADD, 16'hffff, 15'h7fff, 15'h7fff, 8'hff, 0, 0));
      queue_req(mk(FUNC_SCAN, 0, 0, 0, 0, 0, 0));
      queue_req(mk(FUNC_POS, 16'hffff, 0, 0, 0, 16'h7fff, 16'h7fff));
      queue_req(mk(FUNC_ADD, 16'h0000, 15'h7fff, 15'h7fff, 8'h00, 0, 0));
      queue_req(mk(FUNC_POS, 16'h0000, 0, 0, 0, 16'h8000, 16'h8000));
      queue_req(mk(FUNC_SCAN, 0, 0, 0, 0, 0, 0));
      queue_req(mk(FUNC_POS, 16'h0000, 0, 0, 0, 16'h7ffe, 16'h7ffe));
      queue_req(mk(FUNC_SCAN, 0, 0, 0, 0, 0, 0));
      queue_req(mk(FUNC_ADD, 16'h0000, 5, 5, 8'h01, 0, 0)); // duplicate id
      queue_req(mk(FUNC_POS, 16'h0000, 0, 0, 0, 16'h0000, 16'h0000));
      queue_req(mk(FUNC_POS, 16'h1234, 0, 0, 0, 16'h5555, 16'haaaa));
      for (int i = 0; i < 6; i++)
         queue_req(mk(FUNC_ADD, 16'(i + 1), 10, 10, 8'(i), 0, 0));
      queue_req(mk(FUNC_ADD, 16'h0077, 1, 1, 1, 0, 0)); // refused
      queue_req(mk(FUNC_NONE, 16'h0001, 15'h7fff, 15'h7fff, 8'hff,
                   16'hffff, 16'hffff));
      queue_req(mk(FUNC_SCAN, 0, 0, 0, 0, 0, 0));
      issued = pending_reqs.size();

      // random: rounds of fill, place, scan; reset is never reapplied so the
      // table stays full after the first round and later rounds stress moves
      while (issued < 430) begin
         n_ids = N_ENT;
         for (int i = 0; i < N_ENT; i++) ids[i] = 16'($urandom_range(12));
         for (int i = 0; i < 3; i++) begin
            queue_req(mk(FUNC_ADD, ids[$urandom_range(n_ids - 1)],
                         pick_size(), pick_size(), 8'($urandom_range(3)),
                         16'($urandom), 16'($urandom)));
            issued++;
         end
         for (int i = 0; i < 12; i++) begin
            logic [1:0] f;
            f = ($urandom_range(9) == 0) ? 2'($urandom) : FUNC_POS;
            queue_req(mk(f, ($urandom_range(7) == 0) ? 16'($urandom)
                            : 16'($urandom_range(12)),
                         15'($urandom), 15'($urandom), 8'($urandom),
                         pick_pos(), pick_pos()));
            issued++;
         end
         queue_req(mk(FUNC_SCAN, 16'($urandom), 15'($urandom), 15'($urandom),
                      8'($urandom), 16'($urandom), 16'($urandom)));
         issued++;
      end

      wait (pending_reqs.size() == 0 && !req_chan.valid);
      wait (expected_beats.size() == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      tbl_count = 0;
   end
endmodule

// ===== files.f =====
rtl/core/tfap_pkg.sv
rtl/core/tfap_if.sv
rtl/core/tfap_cell.sv
rtl/core/team_filtered_aabb_pair_scan.sv
rtl/core/tfap_checker.sv
dv/tfap_tb_if.sv
dv/testbench.sv
